// ===== rtl/midi_note_voice_allocator_macros.svh =====
// Assertion macros for the MIDI note voice allocator.
`ifndef MIDI_NOTE_VOICE_ALLOCATOR_MACROS_SVH
`define MIDI_NOTE_VOICE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MNVA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MNVA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mnva_pkg.sv =====
package mnva_pkg;

  localparam int unsigned VoiceCountDef = 8;
  localparam int unsigned FreqW         = 14;
  localparam int unsigned VelW          = 7;
  localparam int unsigned KeyW          = 7;
  localparam int unsigned VoiceIdxOutW  = 3;

  typedef enum logic [2:0] {
    EV_ASSIGNED = 3'd0,
    EV_RELEASED = 3'd1,
    EV_NO_FREE  = 3'd2,
    EV_NO_MATCH = 3'd3,
    EV_REJECTED = 3'd4
  } event_e;

  localparam logic [7:0] StatusMask    = 8'hE0;
  localparam logic [7:0] StatusNote    = 8'h80;
  localparam logic [3:0] NibbleNoteOn  = 4'b1001;

  localparam logic [FreqW-1:0] KeyHz [128] = '{
    14'd8,     14'd9,     14'd9,     14'd10,    14'd10,    14'd11,    14'd12,    14'd12,
    14'd13,    14'd14,    14'd15,    14'd15,    14'd16,    14'd17,    14'd18,    14'd19,
    14'd21,    14'd22,    14'd23,    14'd24,    14'd26,    14'd28,    14'd29,    14'd31,
    14'd33,    14'd35,    14'd37,    14'd39,    14'd41,    14'd44,    14'd46,    14'd49,
    14'd52,    14'd55,    14'd58,    14'd62,    14'd65,    14'd69,    14'd73,    14'd78,
    14'd82,    14'd87,    14'd92,    14'd98,    14'd104,   14'd110,   14'd117,   14'd123,
    14'd131,   14'd139,   14'd147,   14'd156,   14'd165,   14'd175,   14'd185,   14'd196,
    14'd208,   14'd220,   14'd233,   14'd247,   14'd262,   14'd277,   14'd294,   14'd311,
    14'd330,   14'd349,   14'd370,   14'd392,   14'd415,   14'd440,   14'd466,   14'd494,
    14'd523,   14'd554,   14'd587,   14'd622,   14'd659,   14'd698,   14'd740,   14'd784,
    14'd831,   14'd880,   14'd932,   14'd988,   14'd1047,  14'd1109,  14'd1175,  14'd1245,
    14'd1319,  14'd1397,  14'd1480,  14'd1568,  14'd1661,  14'd1760,  14'd1865,  14'd1976,
    14'd2093,  14'd2217,  14'd2349,  14'd2489,  14'd2637,  14'd2794,  14'd2960,  14'd3136,
    14'd3322,  14'd3520,  14'd3729,  14'd3951,  14'd4186,  14'd4435,  14'd4699,  14'd4978,
    14'd5274,  14'd5588,  14'd5920,  14'd6272,  14'd6645,  14'd7040,  14'd7459,  14'd7902,
    14'd8372,  14'd8870,  14'd9397,  14'd9956,  14'd10548, 14'd11175, 14'd11840, 14'd12544
  };

endpackage

// ===== rtl/midi_note_voice_allocator.sv =====
// Parses a serial MIDI byte stream (note-on and note-off on any channel) and manages a pool of
// VOICE_COUNT voices held in a single-port voice memory with a registered read. A byte that
// does not end a message leaves the block idle and ready for the next byte. A completed
// message with key zero is reported as rejected without a walk. Any other completed message
// starts a walk from voice 0 that reads each voice and then compares and writes it back,
// stopping at the first hit or the last voice, and then stages its result. No byte is taken
// during the walk. A finished result sits in an output register, so bytes keep flowing while
// it waits to be taken, up to the end of the next message. Voice entries carry per-entry valid
// flags cleared by reset, so the block is ready right after reset with no clearing pass.
`include "midi_note_voice_allocator_macros.svh"

module midi_note_voice_allocator
  import mnva_pkg::*;
#(
  parameter int unsigned VOICE_COUNT = VoiceCountDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              midi_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2:0]              event_status_o,
  output logic [VoiceIdxOutW-1:0] voice_index_o,
  output logic [FreqW-1:0]        note_frequency_o,
  output logic [VelW-1:0]         note_velocity_o
);

  localparam int unsigned VidxW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int unsigned VextW = (VidxW > VoiceIdxOutW) ? VidxW : VoiceIdxOutW;
  localparam logic [VidxW-1:0] LastIdx = VidxW'(VOICE_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CK,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    POS_STATUS = 2'd0,
    POS_KEY    = 2'd1,
    POS_VEL    = 2'd2,
    POS_UNUSED = 2'd3
  } parse_e;

  state_e              state_q;
  parse_e              pos_q, pos_eff, pos_d;
  logic                is_on_q;
  logic [KeyW-1:0]     key_q;
  logic [FreqW-1:0]    freq_q;
  logic [VelW-1:0]     vel_q;
  logic [VidxW-1:0]    walk_idx_q;
  logic [VOICE_COUNT-1:0] valid_q;

  logic [FreqW-1:0]    mem [VOICE_COUNT];
  logic [FreqW-1:0]    rdata_q;
  logic                rvalid_q;
  logic [FreqW-1:0]    cur_freq;
  logic                hit;
  logic                mem_we;
  logic [FreqW-1:0]    mem_wdata;

  event_e              res_status_q;
  logic [VidxW-1:0]    res_idx_q;
  logic [FreqW-1:0]    res_freq_q;
  logic [VelW-1:0]     res_vel_q;

  logic                out_valid_q;
  event_e              out_status_q;
  logic [VidxW-1:0]    out_idx_q;
  logic [FreqW-1:0]    out_freq_q;
  logic [VelW-1:0]     out_vel_q;
  logic [VextW-1:0]    out_idx_ext;

  logic                in_acc;
  logic                out_free;
  logic                msg_done;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (pos_q)
      POS_KEY, POS_VEL: pos_eff = midi_byte_i[7] ? POS_STATUS : pos_q;
      default:          pos_eff = POS_STATUS;
    endcase
    msg_done = 1'b0;
    unique case (pos_eff)
      POS_KEY: pos_d = POS_VEL;
      POS_VEL: begin
        pos_d    = POS_STATUS;
        msg_done = 1'b1;
      end
      default: pos_d = ((midi_byte_i & StatusMask) == StatusNote) ? POS_KEY : POS_STATUS;
    endcase
  end

  assign cur_freq  = rvalid_q ? rdata_q : '0;
  assign hit       = is_on_q ? (cur_freq == '0) : (cur_freq == freq_q);
  assign mem_we    = (state_q == ST_CK) && hit;
  assign mem_wdata = is_on_q ? freq_q : '0;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD) begin
      rdata_q <= mem[walk_idx_q];
    end
    if (mem_we) begin
      mem[walk_idx_q] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= POS_STATUS;
      is_on_q      <= 1'b0;
      key_q        <= '0;
      freq_q       <= '0;
      vel_q        <= '0;
      walk_idx_q   <= '0;
      valid_q      <= '0;
      rvalid_q     <= 1'b0;
      res_status_q <= EV_REJECTED;
      res_idx_q    <= '0;
      res_freq_q   <= '0;
      res_vel_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= EV_REJECTED;
      out_idx_q    <= '0;
      out_freq_q   <= '0;
      out_vel_q    <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            pos_q <= pos_d;
            if (pos_eff == POS_KEY) begin
              key_q <= midi_byte_i[KeyW-1:0];
            end
            if (pos_eff == POS_STATUS && pos_d == POS_KEY) begin
              is_on_q <= (midi_byte_i[7:4] == NibbleNoteOn);
            end
            if (msg_done) begin
              vel_q      <= midi_byte_i[VelW-1:0];
              freq_q     <= KeyHz[key_q];
              walk_idx_q <= '0;
              if (key_q == '0) begin
                res_status_q <= EV_REJECTED;
                res_idx_q    <= '0;
                res_freq_q   <= '0;
                res_vel_q    <= '0;
                state_q      <= ST_DONE;
              end else begin
                state_q <= ST_RD;
              end
            end
          end
        end
        ST_RD: begin
          rvalid_q <= valid_q[walk_idx_q];
          state_q  <= ST_CK;
        end
        ST_CK: begin
          if (hit) begin
            valid_q[walk_idx_q] <= 1'b1;
            res_status_q <= is_on_q ? EV_ASSIGNED : EV_RELEASED;
            res_idx_q    <= walk_idx_q;
            res_freq_q   <= freq_q;
            res_vel_q    <= is_on_q ? vel_q : '0;
            state_q      <= ST_DONE;
          end else if (walk_idx_q == LastIdx) begin
            res_status_q <= is_on_q ? EV_NO_FREE : EV_NO_MATCH;
            res_idx_q    <= '0;
            res_freq_q   <= freq_q;
            res_vel_q    <= '0;
            state_q      <= ST_DONE;
          end else begin
            walk_idx_q <= walk_idx_q + 1'b1;
            state_q    <= ST_RD;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_idx_q    <= res_idx_q;
            out_freq_q   <= res_freq_q;
            out_vel_q    <= res_vel_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_idx_ext      = VextW'(out_idx_q);
  assign out_valid_o      = out_valid_q;
  assign event_status_o   = out_status_q;
  assign voice_index_o    = out_idx_ext[VoiceIdxOutW-1:0];
  assign note_frequency_o = out_freq_q;
  assign note_velocity_o  = out_vel_q;

  `MNVA_ASSERT_NEXT(a_out_drains, out_valid_o && !out_stall_i && state_q != ST_DONE,
    !out_valid_o, "result taken but output still valid")
  `MNVA_ASSERT_NOW(a_assign_nonzero, mem_we && is_on_q, mem_wdata != '0,
    "note-on writes a free-voice frequency")
  `MNVA_ASSERT_NOW(a_reject_clean, out_valid_o && event_status_o == EV_REJECTED,
    note_frequency_o == '0 && voice_index_o == '0 && note_velocity_o == '0,
    "rejected key reports nonzero fields")
  `MNVA_ASSERT_NOW(a_walk_range, state_q == ST_RD || state_q == ST_CK,
    int'(walk_idx_q) < int'(VOICE_COUNT), "voice walk past last voice")

endmodule
